// File: hw/rtl/masked_neighbor_pad_fill_assert.svh
// Assertion macros used by the padding block's controller.
`ifndef MASKED_NEIGHBOR_PAD_FILL_ASSERT_SVH
`define MASKED_NEIGHBOR_PAD_FILL_ASSERT_SVH
`ifndef SYNTHESIS
`define MNPF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MNPF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MNPF_ASSERT_IMP(label, ante, cons)
`define MNPF_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/mnpf_pkg.sv
// Package with constants, types and helper functions of the padding block.
`timescale 1ns / 1ps
package mnpf_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int RING_LEN  = 2 * MAX_WIDTH + 3;
    localparam int RING_AW   = $clog2(RING_LEN);
    localparam int BL_W      = $clog2(RING_LEN + 1);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EW_W      = $clog2(MAX_WIDTH + 1);
    localparam int WREG_W    = 11;
    localparam int HREG_W    = 13;
    localparam int OFF_W     = RING_AW + 2;
    localparam int PIX_W     = 33;
    localparam int SUM_W     = 11;
    localparam int RCP_W     = 17;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;
    localparam int CFG_W     = 13;
    localparam int SLOT_LAST = 8;
    localparam int SLOT_CTR  = 4;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_READ,
        S_WAIT,
        S_DIV,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic       take;
        logic       capture;
        logic       issue;
        logic [3:0] slot;
        logic       divide;
        logic       load;
    } cmd_t;

    typedef struct packed {
        logic want_release;
        logic out_free;
    } status_t;

    // Reciprocal scaled by 2^16, rounded up; exact for dividends below 2048.
    function automatic logic [RCP_W-1:0] recip(input logic [3:0] n);
        logic [RCP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            default: r = 17'd0;
        endcase
        return r;
    endfunction
endpackage

// File: hw/rtl/mnpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mnpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: hw/rtl/mnpf_ctrl.sv
// Controller state machine sequencing acceptance, window reads and result loading.
`timescale 1ns / 1ps
`include "masked_neighbor_pad_fill_assert.svh"
module mnpf_ctrl import mnpf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);
    state_t     state_reg, state_next;
    logic [3:0] slot_reg, slot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        cmd         = '0;
        cmd.slot    = slot_reg;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && status.want_release) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                cmd.capture = 1'b1;
                slot_next   = '0;
                state_next  = S_READ;
            end
            S_READ: begin
                cmd.issue = 1'b1;
                if (slot_reg == 4'(SLOT_LAST)) begin
                    state_next = S_WAIT;
                end else begin
                    slot_next = slot_reg + 4'd1;
                end
            end
            S_WAIT: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.divide = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MNPF_ASSERT_IMP(a_load_free, cmd.load, status.out_free)
    `MNPF_ASSERT_IMP(a_slot_range, state_reg == S_READ, slot_reg <= 4'(SLOT_LAST))
    `MNPF_ASSERT_NXT(a_release_starts, cmd.take && status.want_release, state_reg == S_ADDR)
endmodule

// File: hw/rtl/mnpf_datapath.sv
// Datapath: pixel history, window address generation, accumulation and averaging.
`timescale 1ns / 1ps
module mnpf_datapath import mnpf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    input  cmd_t                cmd,
    output status_t             status
);
    logic [WREG_W-1:0]   width_reg;
    logic [HREG_W-1:0]   height_reg;
    logic [RING_AW-1:0]  wr_ptr_reg;
    logic [BL_W-1:0]     backlog_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [HREG_W-1:0]   out_row_reg;
    logic [RING_AW-1:0]  ctr_reg;
    logic [COL_W-1:0]    cur_col_reg;
    logic [HREG_W-1:0]   cur_row_reg;
    logic [BL_W-1:0]     bl_cap_reg;
    logic                last_reg;
    logic                rd_nbr_reg;
    logic                rd_ctr_reg;
    logic [PIX_W-1:0]    ctr_pix_reg;
    logic [3:0][SUM_W-1:0] acc_reg;
    logic [3:0]          n_reg;
    logic [3:0][7:0]     avg_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;

    logic [EW_W-1:0]     eff_w;
    logic [HREG_W-1:0]   eff_h;
    logic [BL_W-1:0]     backlog_inc;
    logic [RING_AW:0]    ctr_diff;
    logic [RING_AW-1:0]  ctr_pos;
    logic                col_wrap;
    logic                row_wrap;
    logic                dy_neg, dy_pos, dx_neg, dx_pos;
    logic signed [OFF_W-1:0] d_off;
    logic signed [OFF_W-1:0] raw_addr;
    logic [RING_AW-1:0]  rd_addr;
    logic                nbr_ok;
    logic [PIX_W-1:0]    rd_data;
    logic [PIX_W-1:0]    new_pix;

    assign eff_w = (width_reg == '0) ? EW_W'(1) :
                   (width_reg > WREG_W'(MAX_WIDTH)) ? EW_W'(MAX_WIDTH) : EW_W'(width_reg);
    assign eff_h = (height_reg == '0) ? HREG_W'(1) : height_reg;

    assign backlog_inc = (backlog_reg < BL_W'(RING_LEN)) ? backlog_reg + BL_W'(1) : backlog_reg;
    assign status.want_release = (s_tuser == OP_DRAIN) ? (backlog_reg != '0) :
                                 (13'(backlog_inc) > 13'(eff_w) + 13'd1);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign new_pix = s_tdata[PIX_W-1:0];

    assign ctr_diff = (RING_AW+1)'(wr_ptr_reg) + (RING_AW+1)'(RING_LEN)
                    - (RING_AW+1)'(backlog_reg);
    assign ctr_pos  = (ctr_diff >= (RING_AW+1)'(RING_LEN)) ?
                      RING_AW'(ctr_diff - (RING_AW+1)'(RING_LEN)) : RING_AW'(ctr_diff);

    assign col_wrap = (12'(out_col_reg) + 12'd1 >= 12'(eff_w));
    assign row_wrap = (14'(out_row_reg) + 14'd1 >= 14'(eff_h));

    always_comb begin
        dy_neg = cmd.slot inside {[4'd0:4'd2]};
        dy_pos = cmd.slot inside {[4'd6:4'd8]};
        dx_neg = cmd.slot inside {4'd0, 4'd3, 4'd6};
        dx_pos = cmd.slot inside {4'd2, 4'd5, 4'd8};
        d_off  = dy_neg ? -OFF_W'(eff_w) : (dy_pos ? OFF_W'(eff_w) : '0);
        if (dx_neg) begin
            d_off = d_off - OFF_W'(1);
        end else if (dx_pos) begin
            d_off = d_off + OFF_W'(1);
        end
        nbr_ok = (cmd.slot != 4'(SLOT_CTR))
               && !(dy_neg && cur_row_reg == '0)
               && !(dy_pos && (14'(cur_row_reg) + 14'd1 >= 14'(eff_h)))
               && !(dx_neg && cur_col_reg == '0)
               && !(dx_pos && (12'(cur_col_reg) + 12'd1 >= 12'(eff_w)))
               && (d_off < $signed(OFF_W'(bl_cap_reg)));
        raw_addr = $signed(OFF_W'(ctr_reg)) + d_off;
        if (raw_addr < 0) begin
            rd_addr = RING_AW'(raw_addr + OFF_W'(RING_LEN));
        end else if (raw_addr >= $signed(OFF_W'(RING_LEN))) begin
            rd_addr = RING_AW'(raw_addr - OFF_W'(RING_LEN));
        end else begin
            rd_addr = RING_AW'(raw_addr);
        end
    end

    mnpf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RING_LEN)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (cmd.take && s_tuser == OP_PIXEL),
        .wr_addr (wr_ptr_reg),
        .wr_data (new_pix),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WREG_W'(256);
            height_reg   <= HREG_W'(256);
            wr_ptr_reg   <= '0;
            backlog_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            rd_nbr_reg   <= 1'b0;
            rd_ctr_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_IMAGE_WIDTH) begin
                    width_reg <= cfg_wdata[WREG_W-1:0];
                end else begin
                    height_reg <= cfg_wdata[HREG_W-1:0];
                end
            end
            if (cmd.take && s_tuser == OP_PIXEL) begin
                wr_ptr_reg  <= (wr_ptr_reg == RING_AW'(RING_LEN - 1)) ? '0
                               : wr_ptr_reg + RING_AW'(1);
                backlog_reg <= backlog_inc;
            end
            if (cmd.capture) begin
                if (backlog_reg != '0) begin
                    backlog_reg <= backlog_reg - BL_W'(1);
                end
                if (col_wrap) begin
                    out_col_reg <= '0;
                    out_row_reg <= row_wrap ? '0 : out_row_reg + HREG_W'(1);
                end else begin
                    out_col_reg <= out_col_reg + COL_W'(1);
                end
            end
            rd_nbr_reg <= cmd.issue && nbr_ok;
            rd_ctr_reg <= cmd.issue && (cmd.slot == 4'(SLOT_CTR));
            if (cmd.load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ctr_reg     <= ctr_pos;
            cur_col_reg <= out_col_reg;
            cur_row_reg <= out_row_reg;
            bl_cap_reg  <= backlog_reg;
            last_reg    <= col_wrap && row_wrap;
            acc_reg     <= '0;
            n_reg       <= '0;
        end else if (rd_nbr_reg && rd_data[PIX_W-1]) begin
            for (int k = 0; k < 4; k++) begin
                acc_reg[k] <= acc_reg[k] + SUM_W'(rd_data[8*k +: 8]);
            end
            n_reg <= n_reg + 4'd1;
        end
        if (rd_ctr_reg) begin
            ctr_pix_reg <= rd_data;
        end
        if (cmd.divide) begin
            for (int k = 0; k < 4; k++) begin
                avg_reg[k] <= 8'((PROD_W'(acc_reg[k] + SUM_W'(n_reg >> 1))
                                  * PROD_W'(recip(n_reg))) >> 16);
            end
        end
        if (cmd.load) begin
            m_tlast_reg <= last_reg;
            if (!ctr_pix_reg[PIX_W-1] && n_reg != '0) begin
                m_tdata_reg <= {6'd0, 1'b1, 1'b1, avg_reg[3], avg_reg[2], avg_reg[1], avg_reg[0]};
            end else begin
                m_tdata_reg <= {6'd0, 1'b0, ctr_pix_reg};
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
endmodule

// File: hw/rtl/masked_neighbor_pad_fill.sv
// Top level of the streaming 3x3 neighbour-average padding block.
// Usage: configure image width (index 0) and height (index 1) through the
// write port while idle, then stream pixel words in raster order on the
// s_ channel, with s_tuser low for a pixel and high for a drain word.
// Each unwritten pixel with a written neighbour in the clipped 3x3 window is
// replaced by their rounded average and marked written and filled.
// A result leaves one row and one pixel behind its pixel; after the last
// pixel of a stream, drain words release the results still pending.
// m_tlast marks the result of the last pixel of a frame.
// A word that releases no result is taken without leaving the idle state. A word that
// releases a result occupies the block while the window is read from the
// pixel history through its single read port one entry per cycle, nine
// reads, followed by averaging and the output load.
// The result sits in an output register, so the next word is accepted
// while it waits; a stalled receiver only holds the block when the next
// result is ready to load. Reset returns the size registers to 256 by 256
// and empties the history; no clearing pass is needed.
`timescale 1ns / 1ps
module masked_neighbor_pad_fill import mnpf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // red_in, green_in, blue_in, alpha_in, written_in
    input  logic                s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // red_out, green_out, blue_out, alpha_out,
                                          // written_out, filled
    output logic                m_tlast   // frame_end
);
    cmd_t    cmd;
    status_t status;

    mnpf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mnpf_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the streaming 3x3 neighbour-average padding block.
`timescale 1ns / 1ps
module tb_top;
    import mnpf_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       written;
        logic       filled;
        logic       frame_end;
    } pad_result_t;

    class pad_scoreboard;
        logic [PIX_W-1:0] history[RING_LEN];
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned wr_ptr;
        int unsigned backlog;
        int unsigned col;
        int unsigned row;
        pad_result_t expected_q[$];
        int errors;

        function new();
            foreach (history[i]) history[i] = '0;
            width_reg = 256;
            height_reg = 256;
            wr_ptr = 0;
            backlog = 0;
            col = 0;
            row = 0;
            errors = 0;
        endfunction

        function void set_reg(logic idx, int unsigned value);
            if (idx == REG_IMAGE_WIDTH) width_reg = value & 'h7FF;
            else height_reg = value & 'h1FFF;
        endfunction

        function pad_result_t average_window();
            int unsigned w, h, c, n, idx;
            int unsigned sum[4];
            int d;
            logic [PIX_W-1:0] centre, e;
            pad_result_t r;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
            h = (height_reg == 0) ? 1 : height_reg;
            c = (wr_ptr + RING_LEN - (backlog % RING_LEN)) % RING_LEN;
            centre = history[c];
            n = 0;
            foreach (sum[k]) sum[k] = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                if (dy < 0 && row == 0) continue;
                if (dy > 0 && row + 1 >= h) continue;
                for (int dx = -1; dx <= 1; dx++) begin
                    if (dx == 0 && dy == 0) continue;
                    if (dx < 0 && col == 0) continue;
                    if (dx > 0 && col + 1 >= w) continue;
                    d = dy * int'(w) + dx;
                    if (d >= int'(backlog)) continue;
                    idx = (int'(c) + RING_LEN + d) % RING_LEN;
                    e = history[idx];
                    if (e[32]) begin
                        for (int k = 0; k < 4; k++) sum[k] += e[8*k +: 8];
                        n++;
                    end
                end
            end
            if (!centre[32] && n > 0) begin
                r.red   = 8'((sum[0] + n / 2) / n);
                r.green = 8'((sum[1] + n / 2) / n);
                r.blue  = 8'((sum[2] + n / 2) / n);
                r.alpha = 8'((sum[3] + n / 2) / n);
                r.written = 1'b1;
                r.filled = 1'b1;
            end else begin
                {r.alpha, r.blue, r.green, r.red} = centre[31:0];
                r.written = centre[32];
                r.filled = 1'b0;
            end
            r.frame_end = 1'b0;
            if (col + 1 >= w) begin
                col = 0;
                if (row + 1 >= h) begin
                    row = 0;
                    r.frame_end = 1'b1;
                end else begin
                    row++;
                end
            end else begin
                col++;
            end
            if (backlog > 0) backlog--;
            return r;
        endfunction

        function void note_word(logic op, logic [PIX_W-1:0] pixel);
            int unsigned w;
            w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
            if (op == OP_PIXEL) begin
                history[wr_ptr] = pixel;
                wr_ptr = (wr_ptr + 1) % RING_LEN;
                if (backlog < RING_LEN) backlog++;
                if (backlog > w + 1) expected_q.push_back(average_window());
            end else if (backlog != 0) begin
                expected_q.push_back(average_window());
            end
        endfunction

        function void report(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic last);
            pad_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h last %b", $realtime, data, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            report("red", e.red, data[7:0]);
            report("green", e.green, data[15:8]);
            report("blue", e.blue, data[23:16]);
            report("alpha", e.alpha, data[31:24]);
            report("written", 8'(e.written), 8'(data[32]));
            report("filled", 8'(e.filled), 8'(data[33]));
            report("frame_end", 8'(e.frame_end), 8'(last));
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_addr = 1'b0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    pad_scoreboard sb = new();
    int burst_left = 0;
    int words_sent = 0;

    masked_neighbor_pad_fill i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
    end

    // The receiver alternates between stall patterns, with one long hold-off early on.
    initial begin
        int cycle;
        int mode;
        cycle = 0;
        mode = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (cycle == 1500) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
            if (cycle % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 9) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
            cycle++;
            @(posedge aclk);
        end
    end

    initial begin
        #4_000_000;
        $display("** masked_neighbor_pad_fill: FAILED **");
        $finish;
    end

    task automatic send_word(logic op, logic [PIX_W-1:0] pixel);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(S_DATA_W-PIX_W){1'b0}}, pixel};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, pixel);
        words_sent++;
    endtask

    task automatic settle_and_write(logic idx, int unsigned value);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic drain_all();
        while (sb.backlog != 0) send_word(OP_DRAIN, PIX_W'($urandom));
    endtask

    function automatic logic [PIX_W-1:0] random_pixel(int written_pct);
        logic [PIX_W-1:0] p;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
                0: p[8*k +: 8] = 8'h00;
                1: p[8*k +: 8] = 8'hFF;
                default: p[8*k +: 8] = 8'($urandom);
            endcase
        end
        p[32] = ($urandom_range(0, 99) < written_pct);
        return p;
    endfunction

    task automatic run_frames(int unsigned w, int unsigned h, int frames, int cut);
        int written_pct;
        int total;
        settle_and_write(REG_IMAGE_WIDTH, w);
        settle_and_write(REG_IMAGE_HEIGHT, h);
        written_pct = $urandom_range(5, 95);
        total = frames * ((w == 0 ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w)) * (h == 0 ? 1 : h));
        if (cut > 0 && cut < total) total = cut;
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(0, 99) < 3) send_word(OP_DRAIN, PIX_W'($urandom));
            else send_word(OP_PIXEL, random_pixel(written_pct));
        end
        drain_all();
    endtask

    initial begin
        logic [PIX_W-1:0] corner;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_word(OP_DRAIN, '0);

        settle_and_write(REG_IMAGE_WIDTH, 3);
        settle_and_write(REG_IMAGE_HEIGHT, 3);
        for (int i = 0; i < 9; i++) begin
            case (i)
                0: corner = {1'b1, 32'hFFFF_FFFF};
                2: corner = {1'b1, 32'h0000_0000};
                6: corner = {1'b1, 32'hFF00_FF01};
                8: corner = {1'b1, 32'h00FF_00FE};
                default: corner = {1'b0, 32'h5A5A_A5A5};
            endcase
            send_word(OP_PIXEL, corner);
        end
        send_word(OP_PIXEL, {1'b0, 32'hFFFF_FFFF});
        send_word(OP_DRAIN, '0);
        send_word(OP_PIXEL, {1'b0, 32'h0000_0000});
        drain_all();

        run_frames(0, 0, 3, 0);
        run_frames(1, 1, 3, 0);
        run_frames(1, 6, 2, 0);
        run_frames(6, 1, 2, 0);
        run_frames(2, 3, 2, 0);
        run_frames(1024, 3, 1, 40);
        run_frames(2047, 8191, 1, 30);
        run_frames(1, 4096, 1, 25);
        while (words_sent < 1100) begin
            run_frames($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(1, 3), 0);
        end

        s_tvalid <= 1'b0;
        for (int guard = 0; guard < 200000 && sb.expected_q.size() != 0; guard++)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $realtime, sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("** masked_neighbor_pad_fill: PASSED **");
        end else begin
            $display("** masked_neighbor_pad_fill: FAILED **");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mnpf_pkg.sv
hw/rtl/mnpf_ram.sv
hw/rtl/mnpf_ctrl.sv
hw/rtl/mnpf_datapath.sv
hw/rtl/masked_neighbor_pad_fill.sv
tb/tb_top.sv
